// File: hw/rtl/sha1_byte_stream_hasher_macros.svh
// Assertion macros for the SHA-1 byte stream hasher.
// Included by the top level only; no other dependencies.
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SBH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SBH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbh_pkg.sv
// Types and constants of the SHA-1 byte stream hasher.
// No dependencies; imported by sha1_byte_stream_hasher.
`default_nettype none

package sbh_pkg;

  // Input actions
  typedef enum logic [1:0] {
    ACT_ABSORB = 2'd0,
    ACT_FINISH = 2'd1,
    ACT_START  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_ACCEPT = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_DIGEST = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PAD    = 4'b0010,
    ST_ROUND  = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  // Padding phases
  typedef enum logic [3:0] {
    PH_MARK = 4'b0001,
    PH_ZERO = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_e;

  typedef logic [31:0] word_t;

  localparam word_t H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_ROUND [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] SLOT_LAST  = 6'd63;
  localparam logic [5:0] SLOT_LEN   = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;

endpackage

`default_nettype wire

// File: hw/rtl/sha1_byte_stream_hasher.sv
// SHA-1 hasher fed one message byte per item.
// Depends on sbh_pkg and sha1_byte_stream_hasher_macros.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries action_i and byte_value_i:
//   absorb a byte, finish and return the digest, or start a new message.
//   Output channel (out_valid_o/out_ready_i) returns exactly one item per
//   input item: status_o and the five digest words (zero unless status is
//   the digest code).
//   Sequencing: absorb, start and a repeated finish put their result in the
//   output register at the accepting edge, visible the next cycle. An
//   absorb that fills the 64-byte block then runs the compression: 80
//   rounds on one shared round unit, then one update step; no new item is
//   taken until it is done. A first finish generates the padding bytes
//   (marker, zeros, then the 64-bit length) with one or two compressions
//   and loads the digest into the output register at the last update.
//   The next item is accepted only from idle, while the output register
//   is empty or being emptied in the same cycle; a stalled receiver holds
//   the result and blocks new items.
//   Reset: chaining words to the SHA-1 initial values, bit count and
//   finished flag cleared, output register empty. No clearing pass.
`default_nettype none
`include "sha1_byte_stream_hasher_macros.svh"

module sha1_byte_stream_hasher
  import sbh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  byte_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      digest_word_0_o,
  output logic [31:0]      digest_word_1_o,
  output logic [31:0]      digest_word_2_o,
  output logic [31:0]      digest_word_3_o,
  output logic [31:0]      digest_word_4_o
);

  // Control state
  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  round_q, round_d;
  logic [2:0]  lcnt_q, lcnt_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic        finished_q, finished_d;
  logic        pad_busy_q, pad_busy_d;
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  word_t       h_q [5];
  word_t       h_d [5];

  // Payload state
  logic [511:0] blk_q, blk_d;     // block buffer, also the schedule window
  logic [63:0]  msg_q, msg_d;     // message length for the trailer
  word_t        a_q, b_q, c_q, d_q, e_q;
  word_t        a_d, b_d, c_d, d_d, e_d;
  word_t        dig_q [5];
  word_t        dig_d [5];

  // Datapath helpers
  logic        accept;
  logic [5:0]  slot;
  logic        take_en;
  logic [7:0]  take_byte;
  logic        out_load;
  logic        load_digest;
  status_e     load_status;
  word_t       f_val, k_val, t_val, w_new;

  assign accept = in_valid_i & in_ready_o;
  assign slot   = bitlen_q[8:3];

  // Round function and constant for the current round
  always_comb begin
    if (round_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K_ROUND[0];
    end else if (round_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_ROUND[1];
    end else if (round_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K_ROUND[2];
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_ROUND[3];
    end
  end

  // Shared round adder and schedule expansion (taps at words 0, 2, 8, 13)
  always_comb begin
    word_t x;
    x     = blk_q[511:480] ^ blk_q[447:416] ^ blk_q[255:224] ^ blk_q[95:64];
    w_new = {x[30:0], x[31]};
    t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + blk_q[511:480];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    round_d     = round_q;
    lcnt_d      = lcnt_q;
    bitlen_d    = bitlen_q;
    finished_d  = finished_q;
    pad_busy_d  = pad_busy_q;
    h_d         = h_q;
    blk_d       = blk_q;
    msg_d       = msg_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    e_d         = e_q;
    take_en     = 1'b0;
    take_byte   = 8'h00;
    out_load    = 1'b0;
    load_digest = 1'b0;
    load_status = STAT_ACCEPT;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_ABSORB: begin
              out_load = 1'b1;
              if (finished_q) begin
                load_status = STAT_REJECT;
              end else begin
                take_en   = 1'b1;
                take_byte = byte_value_i;
              end
            end
            ACT_FINISH: begin
              if (finished_q) begin
                out_load    = 1'b1;
                load_digest = 1'b1;
                load_status = STAT_DIGEST;
              end else begin
                msg_d      = bitlen_q;
                pad_busy_d = 1'b1;
                phase_d    = PH_MARK;
                lcnt_d     = 3'd0;
                state_d    = ST_PAD;
              end
            end
            ACT_START: begin
              out_load   = 1'b1;
              h_d        = H_INIT;
              bitlen_d   = 64'd0;
              finished_d = 1'b0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_PAD: begin
        unique case (phase_q)
          PH_MARK: begin
            take_en   = 1'b1;
            take_byte = PAD_MARK;
            phase_d   = PH_ZERO;
          end
          PH_ZERO: begin
            if (slot == SLOT_LEN) begin
              phase_d = PH_LEN;
            end else begin
              take_en = 1'b1;
            end
          end
          PH_LEN: begin
            take_en   = 1'b1;
            take_byte = msg_q[63:56];
            msg_d     = {msg_q[55:0], 8'h00};
            lcnt_d    = lcnt_q + 3'd1;
            if (lcnt_q == 3'd7) begin
              phase_d = PH_DONE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_ROUND: begin
        e_d     = d_q;
        d_d     = c_q;
        c_d     = {b_q[1:0], b_q[31:2]};
        b_d     = a_q;
        a_d     = t_val;
        blk_d   = {blk_q[479:0], w_new};
        round_d = round_q + 7'd1;
        if (round_q == ROUND_LAST) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        h_d[4] = h_q[4] + e_q;
        state_d = ST_IDLE;
        if (pad_busy_q) begin
          if (phase_q == PH_DONE) begin
            finished_d  = 1'b1;
            pad_busy_d  = 1'b0;
            out_load    = 1'b1;
            load_digest = 1'b1;
            load_status = STAT_DIGEST;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Byte intake: shift into the block, count bits, compress on a full block
    if (take_en) begin
      blk_d    = {blk_q[503:0], take_byte};
      bitlen_d = bitlen_q + 64'd8;
      if (slot == SLOT_LAST) begin
        state_d = ST_ROUND;
        round_d = 7'd0;
        a_d     = h_q[0];
        b_d     = h_q[1];
        c_d     = h_q[2];
        d_d     = h_q[3];
        e_d     = h_q[4];
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    status_d    = status_q;
    dig_d       = dig_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      status_d    = load_status;
      for (int i = 0; i < 5; i++) begin
        dig_d[i] = load_digest ? h_d[i] : 32'd0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MARK;
      round_q     <= 7'd0;
      lcnt_q      <= 3'd0;
      bitlen_q    <= 64'd0;
      finished_q  <= 1'b0;
      pad_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= STAT_ACCEPT;
      h_q         <= H_INIT;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      round_q     <= round_d;
      lcnt_q      <= lcnt_d;
      bitlen_q    <= bitlen_d;
      finished_q  <= finished_d;
      pad_busy_q  <= pad_busy_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      h_q         <= h_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    msg_q <= msg_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
    dig_q <= dig_d;
  end

  assign in_ready_o      = (state_q == ST_IDLE) & (~out_valid_q | out_ready_i);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign digest_word_0_o = dig_q[0];
  assign digest_word_1_o = dig_q[1];
  assign digest_word_2_o = dig_q[2];
  assign digest_word_3_o = dig_q[3];
  assign digest_word_4_o = dig_q[4];

  // Checks
  `SBH_ASSERT_IMP(a_compress_on_full, clk_i, rst_ni, (state_q != ST_ROUND) && (state_d == ST_ROUND), slot == SLOT_LAST, "compression started on a partial block")
  `SBH_ASSERT_NXT(a_round_to_update, clk_i, rst_ni, (state_q == ST_ROUND) && (round_q == ROUND_LAST), state_q == ST_UPDATE, "last round not followed by update")
  `SBH_ASSERT_NXT(a_finish_emits, clk_i, rst_ni, (state_q == ST_UPDATE) && pad_busy_q && (phase_q == PH_DONE), out_valid_q && finished_q && (status_q == STAT_DIGEST), "padding done without digest")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for sha1_byte_stream_hasher: directed and random byte
// streams, with a built-in SHA-1 predictor checking every status and digest.
// Depends on sbh_pkg and the RTL of sha1_byte_stream_hasher.
`default_nettype none

module testbench
  import sbh_pkg::*;
();

  // Expected content of one result item
  typedef struct packed {
    status_e     status;
    logic [31:0] d0;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [31:0] d3;
    logic [31:0] d4;
  } hash_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_NOP;
  logic [7:0]  byte_value_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] digest_word_0_o;
  logic [31:0] digest_word_1_o;
  logic [31:0] digest_word_2_o;
  logic [31:0] digest_word_3_o;
  logic [31:0] digest_word_4_o;

  // Predictor state
  word_t       sha_h [5];
  logic [7:0]  sha_block [64];
  logic [63:0] sha_bit_count;
  logic        sha_finished;

  hash_result_t hash_results_due [$];
  int           mismatch_count = 0;
  int           hashed_items = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           rx_hold_req = 0;
  int           rx_hold_left = 0;

  sha1_byte_stream_hasher i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .byte_value_i    (byte_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .digest_word_0_o (digest_word_0_o),
    .digest_word_1_o (digest_word_1_o),
    .digest_word_2_o (digest_word_2_o),
    .digest_word_3_o (digest_word_3_o),
    .digest_word_4_o (digest_word_4_o)
  );

  // Clock, period 10
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // SHA-1 predictor
  // ---------------------------------------------------------------------------
  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void sha_init_words();
    int i;
    for (i = 0; i < 5; i++) sha_h[i] = H_INIT[i];
  endfunction

  // 80 rounds over the full block buffer
  function automatic void sha_compress();
    word_t w [16];
    word_t a, b, c, d, e, f, k, t;
    int    i;
    for (i = 0; i < 16; i++) begin
      w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
    end
    a = sha_h[0];
    b = sha_h[1];
    c = sha_h[2];
    d = sha_h[3];
    e = sha_h[4];
    for (i = 0; i < 80; i++) begin
      if (i >= 16) begin
        w[i & 15] = rotl(w[(i + 13) & 15] ^ w[(i + 8) & 15] ^ w[(i + 2) & 15] ^ w[i & 15], 1);
      end
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_ROUND[0];
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_ROUND[1];
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_ROUND[2];
      end else begin
        f = b ^ c ^ d;
        k = K_ROUND[3];
      end
      t = rotl(a, 5) + f + e + k + w[i & 15];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    sha_h[0] += a;
    sha_h[1] += b;
    sha_h[2] += c;
    sha_h[3] += d;
    sha_h[4] += e;
  endfunction

  // Store a byte at the slot given by the bit count; compress on a full block
  function automatic void sha_take_byte(logic [7:0] v);
    logic [5:0] slot;
    slot = sha_bit_count[8:3];
    sha_block[slot] = v;
    sha_bit_count += 64'd8;
    if (slot == SLOT_LAST) sha_compress();
  endfunction

  // Advance the predictor by one accepted item and queue its result
  function automatic void sha1_predict(action_e act, logic [7:0] v);
    hash_result_t r;
    logic [63:0]  msg_len;
    int           i;
    r = '0;
    r.status = STAT_ACCEPT;
    case (act)
      ACT_ABSORB: begin
        if (sha_finished) begin
          r.status = STAT_REJECT;
        end else begin
          sha_take_byte(v);
          hashed_items++;
        end
      end
      ACT_FINISH: begin
        if (!sha_finished) begin
          msg_len = sha_bit_count;
          sha_take_byte(PAD_MARK);
          while (sha_bit_count[8:3] != SLOT_LEN) sha_take_byte(8'h00);
          for (i = 0; i < 8; i++) sha_take_byte(msg_len[63 - 8*i -: 8]);
          sha_finished = 1'b1;
        end
        r.status = STAT_DIGEST;
        r.d0 = sha_h[0];
        r.d1 = sha_h[1];
        r.d2 = sha_h[2];
        r.d3 = sha_h[3];
        r.d4 = sha_h[4];
        hashed_items++;
      end
      ACT_START: begin
        sha_init_words();
        sha_bit_count = '0;
        sha_finished = 1'b0;
        hashed_items++;
      end
      default: ;
    endcase
    hash_results_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver and receiver
  // ---------------------------------------------------------------------------
  // Offer one item, hold it until accepted, then update the predictor
  task automatic send_item(input action_e act, input logic [7:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    byte_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sha1_predict(act, v);
  endtask

  // Stop offering and wait until every queued result has arrived
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hash_results_due.size() != 0) @(posedge clk_i);
  endtask

  // Receiver ready: random stalls plus requested long hold-offs
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input hash_result_t got,
                                 input hash_result_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: got status %0d digest %h %h %h %h %h", $realtime, what,
               got.status, got.d0, got.d1, got.d2, got.d3, got.d4);
      $display("[%0t] %s: exp status %0d digest %h %h %h %h %h", $realtime, what,
               want.status, want.d0, want.d1, want.d2, want.d3, want.d4);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    hash_result_t got;
    hash_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, digest_word_0_o, digest_word_1_o, digest_word_2_o,
             digest_word_3_o, digest_word_4_o};
      if (hash_results_due.size() == 0) begin
        report_mismatch("unexpected result item", got, '0);
      end else begin
        want = hash_results_due.pop_front();
        if (got.status !== want.status || got.d0 !== want.d0 || got.d1 !== want.d1 ||
            got.d2 !== want.d2 || got.d3 !== want.d3 || got.d4 !== want.d4) begin
          report_mismatch("result mismatch", got, want);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, every action, reject and re-emit cases
  task automatic test_directed_cases();
    send_item(ACT_FINISH, 8'h00);   // digest of the empty message from reset
    send_item(ACT_FINISH, 8'hFF);   // repeated finish re-emits
    send_item(ACT_ABSORB, 8'h00);   // absorb after finish is rejected
    send_item(ACT_ABSORB, 8'hFF);
    send_item(ACT_NOP, 8'hFF);
    send_item(ACT_START, 8'h00);
    send_item(ACT_ABSORB, 8'h61);   // "abc"
    send_item(ACT_ABSORB, 8'h62);
    send_item(ACT_ABSORB, 8'h63);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_START, 8'hFF);
    send_item(ACT_ABSORB, 8'h00);
    send_item(ACT_ABSORB, 8'hFF);
    send_item(ACT_NOP, 8'h00);      // ignored mid-message
    send_item(ACT_START, 8'h5A);    // abandon the message
    send_item(ACT_ABSORB, 8'h55);
    send_item(ACT_ABSORB, 8'hAA);
    send_item(ACT_FINISH, 8'hFF);
    send_item(ACT_FINISH, 8'h00);
    send_item(ACT_NOP, 8'hA5);
    send_item(ACT_START, 8'h00);
  endtask

  // Mostly well-formed messages of random length, with some noise
  task automatic test_random_messages(input int n_items);
    int target;
    int len;
    int i;
    target = hashed_items + n_items;
    while (hashed_items < target) begin
      // a missing start after a finish leaves the message finished: absorbs get rejected
      if ($urandom_range(99) < 90) send_item(ACT_START, 8'($urandom_range(255)));
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: len = $urandom_range(12);
        6, 7:             len = $urandom_range(65, 55);   // padding boundaries
        8:                len = $urandom_range(130, 112);
        default:          len = $urandom_range(70);
      endcase
      for (i = 0; i < len; i++) begin
        if ($urandom_range(99) < 2) send_item(ACT_NOP, 8'($urandom_range(255)));
        send_item(ACT_ABSORB, 8'($urandom_range(255)));
      end
      // some messages are abandoned without a finish
      if ($urandom_range(99) >= 8) begin
        send_item(ACT_FINISH, 8'($urandom_range(255)));
        if ($urandom_range(99) < 15) send_item(ACT_FINISH, 8'($urandom_range(255)));
        if ($urandom_range(99) < 10) send_item(ACT_ABSORB, 8'($urandom_range(255)));
      end
    end
  endtask

  // Long receiver stall while the sender keeps offering items
  task automatic test_receiver_holdoff();
    int saved_pct;
    int i;
    saved_pct   = tx_idle_pct;
    tx_idle_pct = 0;
    rx_hold_req = 300;
    send_item(ACT_START, 8'($urandom_range(255)));
    for (i = 0; i < 70; i++) send_item(ACT_ABSORB, 8'($urandom_range(255)));
    send_item(ACT_FINISH, 8'($urandom_range(255)));
    tx_idle_pct = saved_pct;
  endtask

  // Sender pauses until all results are in, then idles a little longer
  task automatic test_sender_pause();
    wait_results_drained();
    repeat ($urandom_range(20, 1)) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    sha_init_words();
    sha_bit_count = '0;
    sha_finished  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 14;
    rx_idle_pct = 63;
    test_directed_cases();
    test_random_messages(230);
    test_sender_pause();

    tx_idle_pct = 63;
    rx_idle_pct = 14;
    test_random_messages(230);
    test_receiver_holdoff();
    test_sender_pause();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_messages(240);

    wait_results_drained();
    repeat (250) @(posedge clk_i);
    if (mismatch_count == 0 && hash_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sbh_pkg.sv
hw/rtl/sha1_byte_stream_hasher.sv
tb/sv/testbench.sv
